// ===== rtl/ledfx_pkg.sv =====
// Shared constants for the LED strip effect pixel generator.
// Register indexes, effect and channel codes, field widths and table constants.
package ledfx_pkg;

	localparam int W_IDX   = 10;
	localparam int W_STEP  = 32;
	localparam int W_LEN   = 11;
	localparam int W_CFG   = 64;
	localparam int W_CIDX  = 3;

	localparam int LED_COUNT_MAX = 1024;
	localparam int COS_DEPTH_DEF = 1024;

	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam longint unsigned TAYLOR_DIV [7] = '{2, 12, 30, 56, 90, 132, 182};

	// Register indexes on the configuration port.
	localparam logic [W_CIDX-1:0] REG_EFFECT_CONTROL   = 3'd0;
	localparam logic [W_CIDX-1:0] REG_BASE_COLOR       = 3'd1;
	localparam logic [W_CIDX-1:0] REG_SINE_OFFSET_GAIN = 3'd2;
	localparam logic [W_CIDX-1:0] REG_SINE_PERIOD      = 3'd3;
	localparam logic [W_CIDX-1:0] REG_SINE_PHASE_SPEED = 3'd4;
	localparam logic [W_CIDX-1:0] REG_FADE_COLORS      = 3'd5;
	localparam logic [W_CIDX-1:0] REG_TOTAL_STEPS      = 3'd6;
	localparam logic [W_CIDX-1:0] REG_STRIP_LENGTH     = 3'd7;

	// Effect codes in bits 3:2 of effect_control.
	localparam logic [1:0] EFF_SINE_FIXED   = 2'd0;
	localparam logic [1:0] EFF_SINE_INDEXED = 2'd1;
	localparam logic [1:0] EFF_FADE         = 2'd2;
	localparam logic [1:0] EFF_NONE         = 2'd3;

	// Channel select code that computes all three channels.
	localparam logic [1:0] CH_ALL = 2'd3;

endpackage

// ===== rtl/led_strip_effect_pixel_generator_core.sv =====
// LED strip effect pixel generator, top level: registers, sine datapath, channel select.
// The pipeline is built around bit-per-stage dividers for the period, the position and
// the fade quotients.
// Throughput is one item per cycle; a stalled output holds every stage in place.
// Asynchronous active-low reset empties the pipeline and loads the register defaults.
module led_strip_effect_pixel_generator_core import ledfx_pkg::*; #(
	parameter int COS_TABLE_DEPTH = COS_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [W_IDX-1:0]   led_index,
	input  logic [W_STEP-1:0]  step,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [W_IDX-1:0]   led_number,
	output logic [7:0]         chan0,
	output logic [7:0]         chan1,
	output logic [7:0]         chan2,
	input  logic               cfg_we,
	input  logic [W_CIDX-1:0]  cfg_index,
	input  logic [W_CFG-1:0]   cfg_data
);

	localparam int KW  = $clog2(COS_TABLE_DEPTH);
	localparam int RKW = 32 + KW;
	localparam int SWA = W_IDX + W_STEP;

	logic [3:0]  ctrl_q;
	logic [23:0] base_q;
	logic [31:0] og_q;
	logic [31:0] period_q;
	logic [63:0] ps_q;
	logic [47:0] fadec_q;
	logic [31:0] tsteps_q;
	logic [10:0] slen_q;

	logic        en;
	logic [31:0] p_eff;
	logic [10:0] len_eff;
	logic [1:0]  eff;
	logic [1:0]  sel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q   <= 4'd3;
			base_q   <= '0;
			og_q     <= '0;
			period_q <= 32'd65536;
			ps_q     <= '0;
			fadec_q  <= '0;
			tsteps_q <= '0;
			slen_q   <= 11'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_EFFECT_CONTROL:   ctrl_q   <= cfg_data[3:0];
				REG_BASE_COLOR:       base_q   <= cfg_data[23:0];
				REG_SINE_OFFSET_GAIN: og_q     <= cfg_data[31:0];
				REG_SINE_PERIOD:      period_q <= cfg_data[31:0];
				REG_SINE_PHASE_SPEED: ps_q     <= cfg_data;
				REG_FADE_COLORS:      fadec_q  <= cfg_data[47:0];
				REG_TOTAL_STEPS:      tsteps_q <= cfg_data[31:0];
				REG_STRIP_LENGTH:     slen_q   <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	assign eff = ctrl_q[3:2];
	assign sel = ctrl_q[1:0];

	always_comb begin
		p_eff = (period_q == '0) ? 32'd1 : period_q;
		if (slen_q == '0)
			len_eff = 11'd1;
		else if ({6'b0, slen_q} > 17'(LED_COUNT_MAX))
			len_eff = 11'(LED_COUNT_MAX);
		else
			len_eff = slen_q;
	end

	// Every stage advances together whenever the output register can move.
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// First divider bank: step, speed and phase modulo the period, and the position.
	logic           d1_valid;
	logic [31:0]    step_mod, spd_mod, phs_mod;
	logic [31:0]    pos_quo;
	logic [SWA-1:0] d1_side;

	ledfx_div #(.DW(32), .QB(32), .SW(SWA)) u_dv_step (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(in_valid),
		.in_rem('0), .in_bits(step), .divisor(p_eff), .in_side({led_index, step}),
		.out_valid(d1_valid), .out_quo(), .out_rem(step_mod), .out_side(d1_side)
	);

	ledfx_div #(.DW(32), .QB(32), .SW(1)) u_dv_spd (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(in_valid),
		.in_rem('0), .in_bits(ps_q[31:0]), .divisor(p_eff), .in_side(1'b0),
		.out_valid(), .out_quo(), .out_rem(spd_mod), .out_side()
	);

	ledfx_div #(.DW(32), .QB(32), .SW(1)) u_dv_phs (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(in_valid),
		.in_rem('0), .in_bits(ps_q[63:32]), .divisor(p_eff), .in_side(1'b0),
		.out_valid(), .out_quo(), .out_rem(phs_mod), .out_side()
	);

	ledfx_div #(.DW(W_LEN), .QB(32), .SW(1)) u_dv_pos (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(in_valid),
		.in_rem('0), .in_bits({6'b0, led_index, 16'b0}), .divisor(len_eff), .in_side(1'b0),
		.out_valid(), .out_quo(pos_quo), .out_rem(), .out_side()
	);

	logic              v_s1;
	logic [63:0]       prod_s1;
	logic [25:0]       pos_s1;
	logic [31:0]       phs_s1;
	logic [W_IDX-1:0]  idx_s1;
	logic [W_STEP-1:0] step_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (en)
			v_s1 <= d1_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= {32'b0, step_mod} * {32'b0, spd_mod};
			pos_s1  <= (eff == EFF_SINE_INDEXED) ? pos_quo[25:0] : '0;
			phs_s1  <= phs_mod;
			{idx_s1, step_s1} <= d1_side;
		end
	end

	// Second bank: the product and the position modulo the period.
	logic              d2_valid;
	logic [31:0]       prod_mod, pos_mod;
	logic [SWA+31:0]   d2_side;

	ledfx_div #(.DW(32), .QB(32), .SW(SWA + 32)) u_dv_prod (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s1),
		.in_rem(prod_s1[63:32]), .in_bits(prod_s1[31:0]), .divisor(p_eff),
		.in_side({idx_s1, step_s1, phs_s1}),
		.out_valid(d2_valid), .out_quo(), .out_rem(prod_mod), .out_side(d2_side)
	);

	ledfx_div #(.DW(32), .QB(32), .SW(1)) u_dv_posm (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s1),
		.in_rem('0), .in_bits({6'b0, pos_s1}), .divisor(p_eff), .in_side(1'b0),
		.out_valid(), .out_quo(), .out_rem(pos_mod), .out_side()
	);

	logic              v_s2, v_s3, v_s4;
	logic [33:0]       sum_s2;
	logic [31:0]       r_s3;
	logic [RKW-1:0]    rk_s4;
	logic [SWA-1:0]    side_s2, side_s3, side_s4;
	logic [33:0]       p2;

	assign p2 = {1'b0, p_eff, 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s2 <= d2_valid;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s2  <= {2'b0, prod_mod} + {2'b0, pos_mod} + {2'b0, d2_side[31:0]};
			side_s2 <= d2_side[SWA+31:32];
			// The sum of three residues is below three periods.
			if (sum_s2 >= p2)
				r_s3 <= 32'(sum_s2 - p2);
			else if (sum_s2 >= {2'b0, p_eff})
				r_s3 <= 32'(sum_s2 - {2'b0, p_eff});
			else
				r_s3 <= sum_s2[31:0];
			side_s3 <= side_s2;
			rk_s4   <= RKW'({{KW{1'b0}}, r_s3} * RKW'(COS_TABLE_DEPTH));
			side_s4 <= side_s3;
		end
	end

	// Table index k = r * depth / period; the quotient is below the depth.
	logic           dk_valid;
	logic [KW-1:0]  k_quo;
	logic [SWA-1:0] dk_side;

	ledfx_div #(.DW(32), .QB(KW), .SW(SWA)) u_dv_k (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s4),
		.in_rem(rk_s4[RKW-1:KW]), .in_bits(rk_s4[KW-1:0]), .divisor(p_eff),
		.in_side(side_s4),
		.out_valid(dk_valid), .out_quo(k_quo), .out_rem(), .out_side(dk_side)
	);

	logic               cs_valid;
	logic signed [15:0] cos_entry;
	logic [SWA-1:0]     cs_side;

	ledfx_cos #(.COS_TABLE_DEPTH(COS_TABLE_DEPTH), .SW(SWA)) u_cos (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(dk_valid),
		.k(k_quo), .in_side(dk_side),
		.out_valid(cs_valid), .entry(cos_entry), .out_side(cs_side)
	);

	logic               v_s5, v_s6, v_s7;
	logic signed [31:0] gp_s5;
	logic signed [32:0] val_s6;
	logic [7:0]         sine_s7;
	logic [SWA-1:0]     side_s5, side_s6;
	logic [W_IDX-1:0]   idx_s7;
	logic [W_STEP-1:0]  step_s7;
	logic [31:0]        scaled;

	// 255 * v as a shift and subtract; only meaningful when 0 <= v <= 2^23.
	assign scaled = {val_s6[23:0], 8'b0} - {8'b0, val_s6[23:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s5 <= cs_valid;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			gp_s5   <= $signed(og_q[15:0]) * cos_entry;
			side_s5 <= cs_side;
			val_s6  <= $signed({{2{og_q[31]}}, og_q[31:16], 15'b0}) + $signed({gp_s5[31], gp_s5});
			side_s6 <= side_s5;
			if (val_s6[32])
				sine_s7 <= 8'd0;
			else if (val_s6[31:0] > 32'h0080_0000)
				sine_s7 <= 8'd255;
			else
				sine_s7 <= scaled[30:23];
			{idx_s7, step_s7} <= side_s6;
		end
	end

	// Fade lanes; lane 0 also carries the index and the sine byte.
	logic             f_valid;
	logic [7:0]       fade0, fade1, fade2;
	logic [W_IDX+7:0] f_side;

	ledfx_fade #(.SW(W_IDX + 8)) u_fade0 (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s7), .step(step_s7),
		.start_byte(fadec_q[47:40]), .end_byte(fadec_q[23:16]), .total_steps(tsteps_q),
		.in_side({idx_s7, sine_s7}),
		.out_valid(f_valid), .out_byte(fade0), .out_side(f_side)
	);

	ledfx_fade #(.SW(1)) u_fade1 (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s7), .step(step_s7),
		.start_byte(fadec_q[39:32]), .end_byte(fadec_q[15:8]), .total_steps(tsteps_q),
		.in_side(1'b0),
		.out_valid(), .out_byte(fade1), .out_side()
	);

	ledfx_fade #(.SW(1)) u_fade2 (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s7), .step(step_s7),
		.start_byte(fadec_q[31:24]), .end_byte(fadec_q[7:0]), .total_steps(tsteps_q),
		.in_side(1'b0),
		.out_valid(), .out_byte(fade2), .out_side()
	);

	logic [7:0] fade_b [3];
	logic [7:0] pick   [3];
	logic [7:0] sine_b;

	assign fade_b[0] = fade0;
	assign fade_b[1] = fade1;
	assign fade_b[2] = fade2;
	assign sine_b    = f_side[7:0];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			if (eff != EFF_NONE && (sel == CH_ALL || sel == 2'(c)))
				pick[c] = (eff == EFF_FADE) ? fade_b[c] : sine_b;
			else
				pick[c] = base_q[23 - 8*c -: 8];
		end
	end

	logic             out_valid_q;
	logic [W_IDX-1:0] num_q;
	logic [7:0]       ch0_q, ch1_q, ch2_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (en)
			out_valid_q <= f_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_q <= f_side[W_IDX+7:8];
			ch0_q <= pick[0];
			ch1_q <= pick[1];
			ch2_q <= pick[2];
		end
	end

	assign out_valid  = out_valid_q;
	assign led_number = num_q;
	assign chan0      = ch0_q;
	assign chan1      = ch1_q;
	assign chan2      = ch2_q;

endmodule

// ===== rtl/ledfx_div.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
// Standalone; carries a valid bit and a side word alongside each item.
module ledfx_div #(
	parameter int DW = 32,
	parameter int QB = 32,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [DW-1:0] in_rem,
	input  logic [QB-1:0] in_bits,
	input  logic [DW-1:0] divisor,
	input  logic [SW-1:0] in_side,
	output logic          out_valid,
	output logic [QB-1:0] out_quo,
	output logic [DW-1:0] out_rem,
	output logic [SW-1:0] out_side
);

	logic          v_s    [QB];
	logic [DW-1:0] rem_s  [QB];
	logic [QB-1:0] bits_s [QB];
	logic [QB-1:0] quo_s  [QB];
	logic [SW-1:0] side_s [QB];

	for (genvar i = 0; i < QB; i++) begin : g_st
		logic          vp;
		logic [DW-1:0] rp;
		logic [QB-1:0] bp;
		logic [QB-1:0] qp;
		logic [SW-1:0] sp;
		logic [DW:0]   trial;
		logic          ge;

		if (i == 0) begin : g_first
			assign vp = in_valid;
			assign rp = in_rem;
			assign bp = in_bits;
			assign qp = '0;
			assign sp = in_side;
		end else begin : g_next
			assign vp = v_s[i-1];
			assign rp = rem_s[i-1];
			assign bp = bits_s[i-1];
			assign qp = quo_s[i-1];
			assign sp = side_s[i-1];
		end

		// The partial remainder stays below the divisor, so one subtract per bit.
		assign trial = {rp, bp[QB-1]};
		assign ge    = trial >= {1'b0, divisor};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (en) begin
				v_s[i] <= vp;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i]  <= ge ? DW'(trial - {1'b0, divisor}) : trial[DW-1:0];
				bits_s[i] <= bp << 1;
				quo_s[i]  <= (qp << 1) | QB'(ge);
				side_s[i] <= sp;
			end
		end
	end

	assign out_valid = v_s[QB-1];
	assign out_quo   = quo_s[QB-1];
	assign out_rem   = rem_s[QB-1];
	assign out_side  = side_s[QB-1];

endmodule

// ===== rtl/ledfx_cos.sv =====
// Cosine lookup: folds a table index into a quarter wave and reads a Q1.15 value.
// Depends on ledfx_pkg for the Taylor constants; the table is built at elaboration.
module ledfx_cos import ledfx_pkg::*; #(
	parameter int COS_TABLE_DEPTH = COS_DEPTH_DEF,
	parameter int SW = 1
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  logic                               in_valid,
	input  logic [$clog2(COS_TABLE_DEPTH)-1:0] k,
	input  logic [SW-1:0]                      in_side,
	output logic                               out_valid,
	output logic signed [15:0]                 entry,
	output logic [SW-1:0]                      out_side
);

	localparam int KW = $clog2(COS_TABLE_DEPTH);
	localparam logic [KW+1:0] D1C = (KW+2)'(COS_TABLE_DEPTH);
	localparam logic [KW+1:0] D2C = (KW+2)'(2 * COS_TABLE_DEPTH);
	localparam logic [KW+1:0] D3C = (KW+2)'(3 * COS_TABLE_DEPTH);

	typedef logic [14:0] rom_t [COS_TABLE_DEPTH+1];

	function automatic logic [14:0] quarter_cos(int unsigned j);
		longint unsigned a;
		longint unsigned x2;
		longint unsigned term;
		longint          sum;
		logic [14:0]     res;
		a    = (HALF_PI_Q30 * longint'(j)) / COS_TABLE_DEPTH;
		x2   = (a * a) >> 30;
		term = 64'd1 << 30;
		sum  = longint'(term);
		for (int n = 1; n <= 7; n++) begin
			term = ((term * x2) >> 30) / TAYLOR_DIV[n-1];
			if ((n & 1) == 1)
				sum = sum - longint'(term);
			else
				sum = sum + longint'(term);
		end
		if (sum < 0)
			sum = 0;
		sum = (sum + 16384) >>> 15;
		if (sum > 32767)
			sum = 32767;
		res = sum[14:0];
		return res;
	endfunction

	function automatic rom_t build_rom();
		rom_t r;
		for (int j = 0; j <= COS_TABLE_DEPTH; j++)
			r[j] = quarter_cos(j);
		return r;
	endfunction

	localparam rom_t COS_ROM = build_rom();

	logic [KW+1:0] m;
	logic [1:0]    quad;
	logic [KW+1:0] e;
	logic [KW+1:0] jx;

	logic          v_s1, v_s2, v_s3;
	logic [KW:0]   j_s1;
	logic          neg_s1, neg_s2;
	logic [14:0]   rom_s2;
	logic signed [15:0] entry_s3;
	logic [SW-1:0] side_s1, side_s2, side_s3;

	always_comb begin
		m = {k, 2'b00};
		if (m >= D3C) begin
			quad = 2'd3;
			e    = m - D3C;
		end else if (m >= D2C) begin
			quad = 2'd2;
			e    = m - D2C;
		end else if (m >= D1C) begin
			quad = 2'd1;
			e    = m - D1C;
		end else begin
			quad = 2'd0;
			e    = m;
		end
		// Odd quadrants read the quarter wave backwards.
		jx = quad[0] ? (D1C - e) : e;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			j_s1     <= jx[KW:0];
			neg_s1   <= (quad == 2'd1) || (quad == 2'd2);
			side_s1  <= in_side;
			rom_s2   <= COS_ROM[j_s1];
			neg_s2   <= neg_s1;
			side_s2  <= side_s1;
			entry_s3 <= neg_s2 ? -$signed({1'b0, rom_s2}) : $signed({1'b0, rom_s2});
			side_s3  <= side_s2;
		end
	end

	assign out_valid = v_s3;
	assign entry     = entry_s3;
	assign out_side  = side_s3;

endmodule

// ===== rtl/ledfx_fade.sv =====
// One fade channel: start + (end - start) * step / total_steps, clamped to a byte.
// Depends on ledfx_div for the quotient stages.
module ledfx_fade #(
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [31:0]   step,
	input  logic [7:0]    start_byte,
	input  logic [7:0]    end_byte,
	input  logic [31:0]   total_steps,
	input  logic [SW-1:0] in_side,
	output logic          out_valid,
	output logic [7:0]    out_byte,
	output logic [SW-1:0] out_side
);

	logic signed [8:0]  dif;
	logic               v_s1, v_s2, v_s3;
	logic [39:0]        ns_s1;
	logic signed [41:0] nd_s1;
	logic signed [41:0] n_s2;
	logic               neg_s3, sat_s3;
	logic [31:0]        rem_s3;
	logic [7:0]         lo_s3;
	logic [SW-1:0]      side_s1, side_s2, side_s3;
	logic [7:0]         quo;
	logic [SW+1:0]      dv_side;

	assign dif = $signed({1'b0, end_byte}) - $signed({1'b0, start_byte});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ns_s1   <= 40'(start_byte) * 40'(total_steps);
			nd_s1   <= dif * $signed({1'b0, step});
			side_s1 <= in_side;
			n_s2    <= $signed({2'b00, ns_s1}) + nd_s1;
			side_s2 <= side_s1;
			// Below 256 * total_steps the quotient fits a byte and n >> 8 is a valid remainder.
			neg_s3  <= n_s2[41];
			sat_s3  <= !n_s2[41] && (n_s2[40:0] >= {1'b0, total_steps, 8'b0});
			rem_s3  <= n_s2[39:8];
			lo_s3   <= n_s2[7:0];
			side_s3 <= side_s2;
		end
	end

	ledfx_div #(.DW(32), .QB(8), .SW(SW + 2)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s3),
		.in_rem   (rem_s3),
		.in_bits  (lo_s3),
		.divisor  (total_steps),
		.in_side  ({neg_s3, sat_s3, side_s3}),
		.out_valid(out_valid),
		.out_quo  (quo),
		.out_rem  (),
		.out_side (dv_side)
	);

	always_comb begin
		if (total_steps == '0)
			out_byte = start_byte;
		else if (dv_side[SW+1])
			out_byte = 8'd0;
		else if (dv_side[SW])
			out_byte = 8'd255;
		else
			out_byte = quo;
	end

	assign out_side = dv_side[SW-1:0];

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the LED strip effect pixel generator core.
// Drives LED index and step items through valid/ready, predicts channel bytes
// from the register settings, and depends on ledfx_pkg and the core RTL.
`timescale 1ns / 100ps

module testbench;
	import ledfx_pkg::*;

	localparam int DEPTH = COS_DEPTH_DEF;
	localparam int LATENCY = 96;

	typedef struct packed {
		logic [W_IDX-1:0]  idx;
		logic [W_STEP-1:0] stp;
	} pixel_req_t;

	typedef struct packed {
		logic [W_IDX-1:0] num;
		logic [7:0]       c0;
		logic [7:0]       c1;
		logic [7:0]       c2;
	} pixel_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [W_IDX-1:0] led_index;
	logic [W_STEP-1:0] step;
	logic out_valid;
	logic out_ready;
	logic [W_IDX-1:0] led_number;
	logic [7:0] chan0, chan1, chan2;
	logic cfg_we;
	logic [W_CIDX-1:0] cfg_index;
	logic [W_CFG-1:0] cfg_data;

	led_strip_effect_pixel_generator_core dut (.*);

	// Shadow copy of the register file.
	logic [3:0]  sh_ctrl;
	logic [23:0] sh_base;
	logic [31:0] sh_offgain;
	logic [31:0] sh_period;
	logic [63:0] sh_phspd;
	logic [47:0] sh_fade;
	logic [31:0] sh_steps;
	logic [10:0] sh_len;

	pixel_req_t pending_items[$];
	pixel_t     expected_pixels[$];
	int send_idle_pct, recv_idle_pct;
	int hold_off;
	int mismatches;
	bit failed;
	bit done;

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	function automatic longint quarter_cos(longint unsigned j);
		longint unsigned a, x2, term;
		longint sum;
		a = (HALF_PI_Q30 * j) / DEPTH;
		x2 = (a * a) >> 30;
		term = 64'd1 << 30;
		sum = term;
		for (int n = 1; n <= 7; n++) begin
			term = ((term * x2) >> 30) / ((2 * n - 1) * (2 * n));
			if (n % 2) sum -= term;
			else sum += term;
		end
		if (sum < 0) sum = 0;
		sum = (sum + 16384) / 32768;
		if (sum > 32767) sum = 32767;
		return sum;
	endfunction

	function automatic longint cosine_q15(longint unsigned k);
		longint unsigned m, e;
		m = 4 * k;
		e = m % DEPTH;
		case ((m / DEPTH) % 4)
			0: return quarter_cos(e);
			1: return -quarter_cos(DEPTH - e);
			2: return -quarter_cos(e);
			default: return quarter_cos(DEPTH - e);
		endcase
	endfunction

	function automatic logic [7:0] sine_level(logic [W_IDX-1:0] idx, logic [31:0] stp,
			bit indexed);
		longint unsigned p, len, pos, r, k;
		longint v;
		p = (sh_period == 0) ? 1 : sh_period;
		len = sh_len;
		if (len == 0) len = 1;
		if (len > LED_COUNT_MAX) len = LED_COUNT_MAX;
		pos = indexed ? (longint'(idx) * 65536) / len : 0;
		r = ((stp % p) * (longint'(sh_phspd[31:0]) % p)) % p;
		r += longint'(sh_phspd[63:32]) % p;
		r += pos % p;
		r %= p;
		k = (r * DEPTH) / p;
		v = longint'($signed(sh_offgain[31:16])) * 32768
			+ longint'($signed(sh_offgain[15:0])) * cosine_q15(k);
		if (v < 0) return 8'd0;
		if (v > (1 << 23)) return 8'd255;
		return 8'((longint'(v) * 255) >> 23);
	endfunction

	function automatic logic [7:0] fade_level(int ch, logic [31:0] stp);
		longint s, e, n;
		longint unsigned q;
		s = sh_fade[47 - 8 * ch -: 8];
		e = sh_fade[23 - 8 * ch -: 8];
		if (sh_steps == 0) return 8'(s);
		n = s * longint'(sh_steps) + (e - s) * longint'(stp);
		if (n < 0) return 8'd0;
		q = longint'(n) / sh_steps;
		return (q > 255) ? 8'd255 : 8'(q);
	endfunction

	function automatic pixel_t predict_pixel(pixel_req_t rq);
		logic [7:0] b [3];
		logic [1:0] sel, eff;
		pixel_t px;
		sel = sh_ctrl[1:0];
		eff = sh_ctrl[3:2];
		for (int c = 0; c < 3; c++) begin
			b[c] = sh_base[23 - 8 * c -: 8];
			if (eff != EFF_NONE && (sel == CH_ALL || sel == c)) begin
				if (eff == EFF_FADE) b[c] = fade_level(c, rq.stp);
				else b[c] = sine_level(rq.idx, rq.stp, eff == EFF_SINE_INDEXED);
			end
		end
		px.num = rq.idx;
		px.c0 = b[0];
		px.c1 = b[1];
		px.c2 = b[2];
		return px;
	endfunction

	// Driver: offers the head of the pending queue, predicting at acceptance.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 0;
			led_index <= '0;
			step <= '0;
		end else begin
			pixel_req_t nx;
			if (in_valid && in_ready) begin
				expected_pixels.push_back(predict_pixel(pending_items.pop_front()));
			end
			if ((!in_valid || in_ready) && pending_items.size() > 0
					&& $urandom_range(99) >= send_idle_pct) begin
				nx = pending_items[0];
				in_valid <= 1;
				led_index <= nx.idx;
				step <= nx.stp;
			end else if (in_valid && in_ready) begin
				in_valid <= 0;
			end
		end
	end

	// Monitor: checks each accepted pixel against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 0;
		end else begin
			pixel_t got, exp_px;
			if (out_valid && out_ready) begin
				got = '{led_number, chan0, chan1, chan2};
				if (expected_pixels.size() == 0) begin
					failed = 1;
					mismatches++;
					if (mismatches <= 10) $display("unexpected pixel %p", got);
				end else begin
					exp_px = expected_pixels.pop_front();
					if (got !== exp_px) begin
						failed = 1;
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected %p, got %p", exp_px, got);
					end
				end
			end
			if (hold_off > 0) begin
				hold_off--;
				out_ready <= 0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	task automatic write_reg(logic [W_CIDX-1:0] ix, logic [63:0] val);
		@(posedge clk);
		cfg_we <= 1;
		cfg_index <= ix;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		case (ix)
			REG_EFFECT_CONTROL:   sh_ctrl = val[3:0];
			REG_BASE_COLOR:       sh_base = val[23:0];
			REG_SINE_OFFSET_GAIN: sh_offgain = val[31:0];
			REG_SINE_PERIOD:      sh_period = val[31:0];
			REG_SINE_PHASE_SPEED: sh_phspd = val;
			REG_FADE_COLORS:      sh_fade = val[47:0];
			REG_TOTAL_STEPS:      sh_steps = val[31:0];
			REG_STRIP_LENGTH:     sh_len = val[10:0];
			default: ;
		endcase
	endtask

	task automatic drain_pipeline();
		wait (pending_items.size() == 0 && !in_valid && expected_pixels.size() == 0);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	task automatic queue_item(logic [9:0] ix, logic [31:0] st);
		pending_items.push_back('{ix, st});
	endtask

	task automatic random_burst(int count);
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(3))
				0: queue_item(10'($urandom_range(1023)), $urandom_range(255));
				1: queue_item(10'($urandom_range(1023)), $urandom);
				default: queue_item(10'($urandom_range(1023)),
					$urandom_range(sh_steps + 40));
			endcase
		end
	endtask

	task automatic random_settings();
		write_reg(REG_EFFECT_CONTROL, 64'($urandom_range(11)));
		write_reg(REG_BASE_COLOR, 64'($urandom));
		write_reg(REG_SINE_OFFSET_GAIN, 64'($urandom));
		write_reg(REG_SINE_PERIOD, ($urandom_range(3) == 0) ? 64'($urandom)
			: 64'($urandom_range(1 << 20)));
		write_reg(REG_SINE_PHASE_SPEED, {$urandom, $urandom});
		write_reg(REG_FADE_COLORS, {$urandom, $urandom});
		write_reg(REG_TOTAL_STEPS, ($urandom_range(3) == 0) ? 64'($urandom)
			: 64'($urandom_range(300)));
		write_reg(REG_STRIP_LENGTH, 64'($urandom_range(2047)));
	endtask

	initial begin
		sh_ctrl = 4'd3; sh_base = 0; sh_offgain = 0; sh_period = 32'd65536;
		sh_phspd = 0; sh_fade = 0; sh_steps = 0; sh_len = 11'd1;
		mismatches = 0; failed = 0; done = 0; hold_off = 0;
		send_idle_pct = 19; recv_idle_pct = 62;
		cfg_we = 0; cfg_index = '0; cfg_data = '0;
		arst_n = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);

		// Reset defaults, then directed extremes.
		queue_item(0, 0);
		queue_item(10'h3FF, 32'hFFFF_FFFF);
		drain_pipeline();

		// Sine on all channels, half offset and half gain.
		write_reg(REG_SINE_OFFSET_GAIN, 64'h0080_0080);
		write_reg(REG_SINE_PERIOD, 0);
		write_reg(REG_SINE_PHASE_SPEED, 64'h0000_4000_0000_4000);
		write_reg(REG_STRIP_LENGTH, 0);
		write_reg(REG_BASE_COLOR, 24'hA5_5A_C3);
		write_reg(REG_EFFECT_CONTROL, {EFF_SINE_FIXED, CH_ALL});
		queue_item(0, 0);
		queue_item(10'h3FF, 32'hFFFF_FFFF);
		drain_pipeline();
		write_reg(REG_SINE_PERIOD, 32'hFFFF_FFFF);
		write_reg(REG_SINE_PHASE_SPEED, 64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(REG_SINE_OFFSET_GAIN, 64'h7FFF_8000);
		write_reg(REG_STRIP_LENGTH, 11'd2047);
		write_reg(REG_EFFECT_CONTROL, {EFF_SINE_INDEXED, 2'd1});
		queue_item(1023, 32'hFFFF_FFFF);
		queue_item(512, 1);
		drain_pipeline();
		write_reg(REG_SINE_PERIOD, 32'h0001_0000);
		write_reg(REG_SINE_OFFSET_GAIN, 64'h8000_7FFF);
		write_reg(REG_STRIP_LENGTH, 11'd3);
		write_reg(REG_EFFECT_CONTROL, {EFF_SINE_INDEXED, 2'd0});
		for (int i = 0; i < 6; i++) queue_item(10'(i), 32'(i));
		drain_pipeline();

		// Fade: zero length, then stepping past the end, plus the unused effect.
		write_reg(REG_FADE_COLORS, 48'hFF_00_80_00_FF_10);
		write_reg(REG_TOTAL_STEPS, 0);
		write_reg(REG_EFFECT_CONTROL, {EFF_FADE, CH_ALL});
		queue_item(7, 5);
		drain_pipeline();
		write_reg(REG_TOTAL_STEPS, 32'hFFFF_FFFF);
		queue_item(1, 32'hFFFF_FFFF);
		drain_pipeline();
		write_reg(REG_TOTAL_STEPS, 10);
		write_reg(REG_EFFECT_CONTROL, {EFF_FADE, 2'd2});
		queue_item(2, 0);
		queue_item(3, 10);
		queue_item(4, 1000);
		queue_item(5, 32'hFFFF_FFFF);
		drain_pipeline();
		write_reg(REG_EFFECT_CONTROL, {EFF_NONE, CH_ALL});
		queue_item(6, 6);
		drain_pipeline();

		// Random phases under the three idling regimes.
		for (int ph = 0; ph < 12; ph++) begin
			if (ph == 4) begin
				send_idle_pct = 62; recv_idle_pct = 19;
			end else if (ph == 8) begin
				send_idle_pct = 0; recv_idle_pct = 0;
			end
			random_settings();
			if (ph == 9) hold_off = 400;
			random_burst(80);
			drain_pipeline();
		end
		done = 1;
		if (!failed) $display("Regression PASS");
		else $display("Regression FAIL");
		$finish;
	end

	initial begin
		#20ms;
		$display("Regression FAIL");
		$finish;
	end

endmodule
